// File: design/ptd_pkg.sv
// Package for the periodic task dispatcher: operation and event codes, and
// the slot entry, write-enable and check-result types.
// No dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned ID_SLOTS = 16;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_TICK     = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    EV_DISPATCH   = 3'd0,
    EV_OVERRUN    = 3'd1,
    EV_TICK_DONE  = 3'd2,
    EV_REGISTERED = 3'd3,
    EV_REJECTED   = 3'd4,
    EV_COMPLETED  = 3'd5,
    EV_IGNORED    = 3'd6
  } event_e;

  // One slot's timing record.
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
  } ptd_entry_t;

  // Per-field write enables for the slot table.
  typedef struct packed {
    logic period_we;
    logic start_we;
    logic stop_we;
  } ptd_wr_t;

  // Per-slot flags fed to the check unit.
  typedef struct packed {
    logic valid;
    logic running;
    logic reported;
  } ptd_flags_t;

  // Verdict of the check unit for one slot.
  typedef struct packed {
    logic dispatch;
    logic overrun;
  } ptd_check_t;

endpackage

// File: design/ptd_slot_table.sv
// Slot table: period, last start and last end per slot, one write port
// with per-field enables and one registered read port. Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_slot_table #(
  parameter int unsigned Slots = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                clk_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  input  ptd_pkg::ptd_wr_t    wr_en_i,
  input  ptd_pkg::ptd_entry_t wr_data_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output ptd_pkg::ptd_entry_t rd_data_o
);
  import ptd_pkg::*;

  ptd_entry_t entry_q [Slots];
  ptd_entry_t rd_data_q;

  // Entries are only used once their slot is valid, so no reset is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en_i.period_we) begin
      entry_q[wr_idx_i].period <= wr_data_i.period;
    end
    if (wr_en_i.start_we) begin
      entry_q[wr_idx_i].start <= wr_data_i.start;
    end
    if (wr_en_i.stop_we) begin
      entry_q[wr_idx_i].stop <= wr_data_i.stop;
    end
  end

  // Fetch the entry for the next cycle's slot.
  always_ff @(posedge clk_i) begin
    rd_data_q <= entry_q[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/ptd_check_unit.sv
// Shared check unit: one wrapped time difference and the due, order and
// overrun compares for the slot under scan. Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_check_unit (
  input  logic [ptd_pkg::TIME_W-1:0] now_i,
  input  logic [ptd_pkg::TIME_W-1:0] max_run_time_i,
  input  ptd_pkg::ptd_entry_t        entry_i,
  input  ptd_pkg::ptd_flags_t        flags_i,
  output ptd_pkg::ptd_check_t        check_o
);
  import ptd_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] run_time;
  logic              due;
  logic              order_ok;

  assign elapsed  = now_i - entry_i.start;
  assign due      = elapsed >= entry_i.period;
  assign order_ok = entry_i.stop >= entry_i.start;
  // A start time of zero (never started, or started at time zero) counts as no run time.
  assign run_time = (entry_i.start != '0) ? elapsed : '0;

  assign check_o.dispatch = flags_i.valid && !flags_i.running && due && order_ok;
  assign check_o.overrun  = flags_i.valid && flags_i.running && !flags_i.reported &&
                            (max_run_time_i != '0) && (run_time >= max_run_time_i);

endmodule

// File: design/periodic_task_dispatcher_core.sv
// Periodic task dispatcher core with overrun watchdog.
// Register and complete items pass through the single-item state, then the output register.
// A tick scans every slot for dispatches, then sends the overruns and tick done;
// one shared check unit scans the slots one per cycle unless a dispatch waits.
// Output stalls hold the sequencer; no new item is taken before the last result is loaded.
// Reset (rst_ni low, asynchronous) clears all slot flags, the alarm limit
// and the sequencer; no clearing pass is needed.
`timescale 1ns / 1ps

module periodic_task_dispatcher_core #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: alarm limit
  input  logic                         cfg_we_i,
  input  logic [ptd_pkg::TIME_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [ptd_pkg::ID_W-1:0]     task_id_i,
  input  logic [ptd_pkg::TIME_W-1:0]   period_i,
  input  logic [ptd_pkg::TIME_W-1:0]   current_time_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   event_kind_o,
  output logic [ptd_pkg::ID_W-1:0]     event_task_o,
  output logic                         last_event_o
);
  import ptd_pkg::*;

  // Task ids are four bits wide, so at most sixteen slots are reachable.
  localparam int unsigned SLOTS = (TASK_SLOTS < ID_SLOTS) ? TASK_SLOTS : ID_SLOTS;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_OVR    = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [TIME_W-1:0] per_q, per_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SLOTS-1:0]  ovr_q, ovr_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [SLOTS-1:0]  running_q, running_d;
  logic [SLOTS-1:0]  reported_q, reported_d;
  logic [TIME_W-1:0] mrt_q;

  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_kind_q, out_kind_d;
  logic [ID_W-1:0]   out_task_q, out_task_d;
  logic              out_last_q, out_last_d;

  logic              out_free;
  logic              id_ok;
  logic [IDX_W-1:0]  id_idx;
  logic [IDX_W-1:0]  ovr_sel;

  logic [IDX_W-1:0]  wr_idx;
  ptd_wr_t           wr_en;
  ptd_entry_t        wr_data;
  ptd_entry_t        rd_data;
  ptd_flags_t        scan_flags;
  ptd_check_t        check;

  // The output register may be refilled in the cycle its transfer completes.
  assign out_free = !out_valid_q || !out_stall_i;
  assign id_ok    = {1'b0, id_q} < (ID_W + 1)'(SLOTS);
  assign id_idx   = id_q[IDX_W-1:0];

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_task_o = out_task_q;
  assign last_event_o = out_last_q;

  // The table read is registered: fetch the slot the scan looks at next.
  ptd_slot_table #(
    .Slots (SLOTS),
    .IdxW  (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_idx_i  (wr_idx),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .rd_idx_i  (idx_d),
    .rd_data_o (rd_data)
  );

  assign scan_flags.valid    = valid_q[idx_q];
  assign scan_flags.running  = running_q[idx_q];
  assign scan_flags.reported = reported_q[idx_q];

  ptd_check_unit u_check (
    .now_i          (now_q),
    .max_run_time_i (mrt_q),
    .entry_i        (rd_data),
    .flags_i        (scan_flags),
    .check_o        (check)
  );

  // Lowest pending overrun goes out first.
  always_comb begin
    ovr_sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (ovr_q[i]) begin
        ovr_sel = IDX_W'(i);
      end
    end
  end

  // Sequencer: one item at a time; the scan walks one slot per cycle unless a dispatch waits.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    per_d       = per_q;
    now_d       = now_q;
    idx_d       = idx_q;
    ovr_d       = ovr_q;
    valid_d     = valid_q;
    running_d   = running_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_task_d  = out_task_q;
    out_last_d  = out_last_q;
    wr_idx      = id_idx;
    wr_en       = '0;
    wr_data     = '{period: per_q, start: now_q, stop: now_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d  = operation_i;
          id_d  = task_id_i;
          per_d = period_i;
          now_d = current_time_i;
          idx_d = '0;
          ovr_d = '0;
          if (operation_i == OP_TICK) begin
            state_d = ST_SCAN;
          end else if (operation_i == OP_NONE) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SINGLE;
          end
        end
      end

      ST_SINGLE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_task_d  = id_q;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
          if (op_q == OP_REGISTER) begin
            if ((per_q == '0) || !id_ok) begin
              out_kind_d = EV_REJECTED;
            end else begin
              // Fill the slot afresh: idle, clock times zero, alarm cleared.
              wr_en              = '{period_we: 1'b1, start_we: 1'b1, stop_we: 1'b1};
              wr_data.start      = '0;
              wr_data.stop       = '0;
              valid_d[id_idx]    = 1'b1;
              running_d[id_idx]  = 1'b0;
              reported_d[id_idx] = 1'b0;
              out_kind_d         = EV_REGISTERED;
            end
          end else begin
            if (id_ok && valid_q[id_idx] && running_q[id_idx]) begin
              wr_en.stop_we      = 1'b1;
              running_d[id_idx]  = 1'b0;
              reported_d[id_idx] = 1'b0;
              out_kind_d         = EV_COMPLETED;
            end else begin
              out_kind_d = EV_IGNORED;
            end
          end
        end
      end

      ST_SCAN: begin
        // Hold on a dispatch until the output register has room.
        if (!check.dispatch || out_free) begin
          wr_idx       = idx_q;
          ovr_d[idx_q] = check.overrun;
          if (check.dispatch) begin
            wr_en.start_we   = 1'b1;
            running_d[idx_q] = 1'b1;
            out_valid_d      = 1'b1;
            out_kind_d       = EV_DISPATCH;
            out_task_d       = ID_W'(idx_q);
            out_last_d       = 1'b0;
          end
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            state_d = ST_OVR;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      ST_OVR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (ovr_q != '0) begin
            reported_d[ovr_sel] = 1'b1;
            ovr_d[ovr_sel]      = 1'b0;
            out_kind_d          = EV_OVERRUN;
            out_task_d          = ID_W'(ovr_sel);
            out_last_d          = 1'b0;
          end else begin
            out_kind_d = EV_TICK_DONE;
            out_task_d = '0;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      running_q   <= '0;
      reported_q  <= '0;
      ovr_q       <= '0;
      idx_q       <= '0;
      mrt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      running_q   <= running_d;
      reported_q  <= reported_d;
      ovr_q       <= ovr_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mrt_q <= cfg_wdata_i;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    per_q      <= per_d;
    now_q      <= now_d;
    out_kind_q <= out_kind_d;
    out_task_q <= out_task_d;
    out_last_q <= out_last_d;
  end

endmodule

// File: bench/periodic_task_dispatcher_core_tb.sv
// Self-checking bench for periodic_task_dispatcher_core: a directed table, then random
// register/tick/complete traffic over several alarm limits, scored by a predictor or typed rows.
// Depends on design/ptd_pkg.sv and design/periodic_task_dispatcher_core.sv.
`timescale 1ns / 1ps

module periodic_task_dispatcher_core_tb;
  import ptd_pkg::*;

  localparam int unsigned SLOTS           = 16;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned ITEMS_PER_PHASE = 57;
  // Idle time after each drain, with margin over a whole tick.
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  // One event as it leaves the block.
  typedef struct packed {
    event_e          kind;
    logic [ID_W-1:0] slot;
    logic            last;
  } outcome_t;

  // One row of the directed table. Where typed is set, the single result is written
  // out by hand (task is the row's id, or 0 for tick done).
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] now;
    logic              typed;
    event_e            kind;
  } step_t;

  localparam int unsigned SCRIPT_LEN = 25;
  localparam step_t SCRIPT [SCRIPT_LEN] = '{
    // empty table: a tick only reports completion
    '{OP_TICK,     4'd0,  32'd0,          32'd0,          1'b1, EV_TICK_DONE},
    '{OP_COMPLETE, 4'd0,  32'hFFFF_FFFF,  32'd0,          1'b1, EV_IGNORED},
    '{OP_REGISTER, 4'd0,  32'd0,          32'd0,          1'b1, EV_REJECTED},
    '{OP_REGISTER, 4'd0,  32'd10,         32'hFFFF_FFFF,  1'b1, EV_REGISTERED},
    '{OP_REGISTER, 4'd15, 32'hFFFF_FFFF,  32'd0,          1'b1, EV_REGISTERED},
    '{OP_REGISTER, 4'd7,  32'd1,          32'd0,          1'b1, EV_REGISTERED},
    // nothing due yet, then two dispatches, then both overrun once
    '{OP_TICK,     4'd0,  32'd0,          32'd0,          1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'd10,         1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'd12,         1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'd13,         1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'd20,         1'b0, EV_DISPATCH},
    '{OP_COMPLETE, 4'd0,  32'd0,          32'd21,         1'b0, EV_DISPATCH},
    '{OP_COMPLETE, 4'd0,  32'd0,          32'd22,         1'b1, EV_IGNORED},
    '{OP_TICK,     4'd0,  32'd0,          32'd25,         1'b0, EV_DISPATCH},
    // re-register a running slot: back to idle with cleared times
    '{OP_REGISTER, 4'd7,  32'd1,          32'd0,          1'b1, EV_REGISTERED},
    '{OP_NONE,     4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, EV_DISPATCH},
    // top of the time range, then wrap past zero
    '{OP_TICK,     4'd0,  32'd0,          32'hFFFF_FFFF,  1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'd2,          1'b0, EV_DISPATCH},
    // end time below start time blocks the slot from then on
    '{OP_COMPLETE, 4'd15, 32'd0,          32'd1,          1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'h8000_0000,  1'b0, EV_DISPATCH},
    '{OP_COMPLETE, 4'd7,  32'd0,          32'hFFFF_FFFF,  1'b0, EV_DISPATCH},
    // dispatch at time zero: the run time then counts as zero, so no alarm
    '{OP_TICK,     4'd0,  32'd0,          32'd0,          1'b0, EV_DISPATCH},
    '{OP_TICK,     4'd0,  32'd0,          32'd100,        1'b0, EV_DISPATCH},
    '{OP_COMPLETE, 4'd14, 32'd0,          32'd5,          1'b1, EV_IGNORED},
    '{OP_REGISTER, 4'd15, 32'd0,          32'd5,          1'b1, EV_REJECTED}
  };

  // Block ports; the bench-driven ones are known from time zero.
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation = OP_NONE;
  logic [ID_W-1:0]   task_id   = '0;
  logic [TIME_W-1:0] period    = '0;
  logic [TIME_W-1:0] cur_time  = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [2:0]        event_kind_o;
  logic [ID_W-1:0]   event_task_o;
  logic              last_event_o;

  // Mirror of the slot table and the alarm limit.
  logic              slot_used  [SLOTS];
  logic              slot_busy  [SLOTS];
  logic              alarm_sent [SLOTS];
  logic [TIME_W-1:0] period_tab [SLOTS];
  logic [TIME_W-1:0] start_tab  [SLOTS];
  logic [TIME_W-1:0] end_tab    [SLOTS];
  logic [TIME_W-1:0] alarm_limit = '0;

  outcome_t    item_events[$];     // events of the latest accepted item
  outcome_t    pending_events[$];  // events still owed by the block, oldest first
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  logic        calm       = 1'b0;  // when set, neither side idles

  periodic_task_dispatcher_core #(
    .TASK_SLOTS(SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .task_id_i     (task_id),
    .period_i      (period),
    .current_time_i(cur_time),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .event_kind_o  (event_kind_o),
    .event_task_o  (event_task_o),
    .last_event_o  (last_event_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Append one event to those of the current item.
  function automatic void note_event(input event_e kind, input logic [ID_W-1:0] slot,
                                     input logic last);
    item_events.insert(item_events.size(), '{kind, slot, last});
  endfunction

  // Append one event to those the block still owes.
  function automatic void owe_event(input outcome_t ev);
    pending_events.insert(pending_events.size(), ev);
  endfunction

  // Work out the events one item causes and advance the mirror.
  function automatic void forecast_events(input op_e op, input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] per,
                                          input logic [TIME_W-1:0] now);
    logic              fresh [SLOTS];
    logic [TIME_W-1:0] run;
    item_events.delete();
    case (op)
      OP_REGISTER: begin
        if (per == '0) begin
          note_event(EV_REJECTED, id, 1'b1);
        end else begin
          slot_used[id]  = 1'b1;
          slot_busy[id]  = 1'b0;
          alarm_sent[id] = 1'b0;
          period_tab[id] = per;
          start_tab[id]  = '0;
          end_tab[id]    = '0;
          note_event(EV_REGISTERED, id, 1'b1);
        end
      end
      OP_TICK: begin
        // dispatch pass first, in slot order
        for (int s = 0; s < SLOTS; s++) begin
          fresh[s] = 1'b0;
          if (slot_used[s] && !slot_busy[s] && (now - start_tab[s]) >= period_tab[s] &&
              end_tab[s] >= start_tab[s]) begin
            start_tab[s] = now;
            slot_busy[s] = 1'b1;
            fresh[s]     = 1'b1;
            note_event(EV_DISPATCH, ID_W'(s), 1'b0);
          end
        end
        // then the watchdog pass; a start time of zero counts as no run time
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_used[s] && slot_busy[s] && !fresh[s] && alarm_limit != '0 &&
              !alarm_sent[s]) begin
            run = (start_tab[s] != '0) ? now - start_tab[s] : '0;
            if (run >= alarm_limit) begin
              alarm_sent[s] = 1'b1;
              note_event(EV_OVERRUN, ID_W'(s), 1'b0);
            end
          end
        end
        note_event(EV_TICK_DONE, '0, 1'b1);
      end
      OP_COMPLETE: begin
        if (slot_used[id] && slot_busy[id]) begin
          end_tab[id]    = now;
          slot_busy[id]  = 1'b0;
          alarm_sent[id] = 1'b0;
          note_event(EV_COMPLETED, id, 1'b1);
        end else begin
          note_event(EV_IGNORED, id, 1'b1);
        end
      end
      default: ;  // unused operation: no events
    endcase
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then log what it owes.
  task automatic send_item(input op_e op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] now,
                           input logic typed, input event_e kind);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    task_id   <= id;
    period    <= per;
    cur_time  <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    forecast_events(op, id, per, now);
    if (typed) begin
      owe_event('{kind, (kind == EV_TICK_DONE) ? '0 : id, 1'b1});
    end else begin
      foreach (item_events[k]) owe_event(item_events[k]);
    end
  endtask

  // Drop valid, wait for every owed event, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_alarm_limit(input logic [TIME_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    alarm_limit = limit;
  endtask

  initial begin
    logic [TIME_W-1:0] limits [PHASES];
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   busy_ids[$];
    op_e               op;
    int unsigned       roll;
    int unsigned       pick;
    int unsigned       placed;

    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s]  = 1'b0;
      slot_busy[s]  = 1'b0;
      alarm_sent[s] = 1'b0;
      period_tab[s] = '1;
      start_tab[s]  = '0;
      end_tab[s]    = '0;
    end

    // Hold reset, then release it on a clock edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part runs with a small alarm limit so overruns show up quickly.
    set_alarm_limit(32'd3);
    foreach (SCRIPT[r]) begin
      send_item(SCRIPT[r].op, SCRIPT[r].id, SCRIPT[r].per, SCRIPT[r].now,
                SCRIPT[r].typed, SCRIPT[r].kind);
    end
    drain();

    // Random part: one phase per alarm limit, the extremes among them.
    limits[0] = '0;
    limits[1] = 32'd1;
    limits[2] = '1;
    limits[3] = $urandom_range(2, 12);
    limits[4] = $urandom;
    wall = $urandom_range(0, 1000);
    for (int p = 0; p < PHASES; p++) begin
      set_alarm_limit(limits[p]);
      calm   = (p == 1);
      placed = 0;
      while (placed < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        id   = ID_W'($urandom_range(0, 15));
        per  = $urandom;
        now  = $urandom;
        if (roll < 15) begin
          // mostly short periods so tasks come due; some zero and some huge
          op   = OP_REGISTER;
          pick = $urandom_range(0, 9);
          if (pick == 0) per = '0;
          else if (pick != 1) per = $urandom_range(1, 20);
        end else if (roll < 60) begin
          // time moves forward in small steps, with the odd jump and a run up to wrap
          op   = OP_TICK;
          pick = $urandom_range(0, 29);
          if (pick == 0) wall = $urandom;
          else if (pick == 1) wall = 32'hFFFF_FFFF - $urandom_range(0, 8);
          else wall = wall + $urandom_range(0, 6);
          now = wall;
        end else if (roll < 95) begin
          // complete mostly a task that is actually running
          op = OP_COMPLETE;
          busy_ids.delete();
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && slot_busy[s]) busy_ids.insert(busy_ids.size(), ID_W'(s));
          end
          if (roll < 88 && busy_ids.size() != 0) begin
            id = busy_ids[$urandom_range(0, busy_ids.size() - 1)];
          end
          if ($urandom_range(0, 9) != 0) now = wall;
        end else begin
          op = OP_NONE;
        end
        send_item(op, id, per, now, 1'b0, EV_DISPATCH);
        if (op != OP_NONE) placed++;
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Score each transfer on the output and pick the stall for the next result.
  always @(posedge clk_i) begin
    outcome_t    want;
    int unsigned hold;
    if (rst_ni && out_valid_o) begin
      if (!out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event: kind %0d task %0d last %0d", $time,
                   event_kind_o, event_task_o, last_event_o);
          errors++;
        end else begin
          want = pending_events.pop_front();
          if (event_kind_o !== want.kind || event_task_o !== want.slot ||
              last_event_o !== want.last) begin
            $display("%0t: event mismatch: expected kind %0d task %0d last %0d, got kind %0d task %0d last %0d",
                     $time, want.kind, want.slot, want.last,
                     event_kind_o, event_task_o, last_event_o);
            errors++;
          end
        end
        hold = calm ? 0 : $urandom_range(0, 15);
        stall_left <= hold;
        out_stall  <= (hold != 0);
      end else begin
        stall_left <= stall_left - 1;
        out_stall  <= (stall_left > 1);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
